/* hdl/suvm_pkg.sv */
`timescale 1ns / 1ps
// Package for the spherical UV mapping block: widths, request/response types,
// the records passed along the cell chains and the CORDIC arctangent table.
// No dependencies.
package suvm_pkg;

   // field and datapath widths
   localparam int COORD_W      = 32;
   localparam int UV_FRAC      = 16;
   localparam int TURN_W       = 32;
   localparam int NIN_W        = COORD_W + 2;
   localparam int NORM_TGT     = 30;
   localparam int NORM_W       = NORM_TGT + 2;
   localparam int LEN_W        = $clog2(NIN_W + 1);
   localparam int LANES        = 3;
   localparam int CW           = NORM_W + 2;
   localparam int AW           = TURN_W + 2;
   localparam int CORDIC_STEPS = 28;
   localparam int STEP_W       = 5;
   localparam int ISQ_STEPS    = NORM_TGT + 1;
   localparam int ISQ_W        = 2 * ISQ_STEPS;

   // pipeline depths used to line up the two angle paths
   localparam int NORM_STAGES  = 3;
   localparam int SQ_STAGES    = 2;
   localparam int U_ALIGN      = SQ_STAGES + ISQ_STEPS;
   localparam int DY_DELAY     = SQ_STAGES + ISQ_STEPS;
   localparam int DEG_DELAY    = SQ_STAGES + ISQ_STEPS + NORM_STAGES + CORDIC_STEPS;

   localparam logic signed [AW-1:0] HALF_TURN = AW'(1) << (TURN_W - 1);
   localparam logic [UV_FRAC:0]     V_MAX     = (UV_FRAC + 1)'(1) << UV_FRAC;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
   } req_type;

   typedef struct packed {
      logic [UV_FRAC-1:0] u_coord;
      logic [UV_FRAC:0]   v_coord;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic [LANES-1:0][NIN_W-1:0]  lane;
   } norm_in_type;

   typedef struct packed {
      logic                         valid;
      logic                         zero;
      logic                         half;
      logic [LANES-1:0][NORM_W-1:0] lane;
   } norm_out_type;

   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] ang;
   } cordic_rec_type;

   typedef struct packed {
      logic             valid;
      logic [ISQ_W-1:0] n;
      logic [ISQ_W-1:0] res;
   } isq_rec_type;

   // atan(2^-i) in units of 2^-32 turn, rounded to nearest
   function automatic logic [AW-1:0] atan_turn(input logic [STEP_W-1:0] idx);
      logic [AW-1:0] t;
      case (idx)
         5'd0:    t = AW'(32'h20000000);
         5'd1:    t = AW'(32'h12E4051E);
         5'd2:    t = AW'(32'h09FB385B);
         5'd3:    t = AW'(32'h051111D4);
         5'd4:    t = AW'(32'h028B0D43);
         5'd5:    t = AW'(32'h0145D7E1);
         5'd6:    t = AW'(32'h00A2F61E);
         5'd7:    t = AW'(32'h00517C55);
         5'd8:    t = AW'(32'h0028BE53);
         5'd9:    t = AW'(32'h00145F2F);
         5'd10:   t = AW'(32'h000A2F98);
         5'd11:   t = AW'(32'h000517CC);
         5'd12:   t = AW'(32'h00028BE6);
         5'd13:   t = AW'(32'h000145F3);
         5'd14:   t = AW'(32'h0000A2FA);
         5'd15:   t = AW'(32'h0000517D);
         5'd16:   t = AW'(32'h000028BE);
         5'd17:   t = AW'(32'h0000145F);
         5'd18:   t = AW'(32'h00000A30);
         5'd19:   t = AW'(32'h00000518);
         5'd20:   t = AW'(32'h0000028C);
         5'd21:   t = AW'(32'h00000146);
         5'd22:   t = AW'(32'h000000A3);
         5'd23:   t = AW'(32'h00000051);
         5'd24:   t = AW'(32'h00000029);
         5'd25:   t = AW'(32'h00000014);
         5'd26:   t = AW'(32'h0000000A);
         5'd27:   t = AW'(32'h00000005);
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

/* hdl/suvm_norm.sv */
`timescale 1ns / 1ps
// Three-stage vector normalizer: scales up to three lanes by a common power of
// two so the largest magnitude lands in [2^29, 2^30). Depends on suvm_pkg.
module suvm_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   fold,
   input  suvm_pkg::norm_in_type  norm_in,
   output suvm_pkg::norm_out_type norm_out
);
   import suvm_pkg::*;

   logic                         v1_ff, v2_ff;
   logic                         half1_ff, half1_in, half2_ff;
   logic [LANES-1:0]             raw_sgn;
   logic [LANES-1:0]             sgn1_ff, sgn1_in, sgn2_ff;
   logic [LANES-1:0][NIN_W-1:0]  mag1_ff, mag1_in, mag2_ff;
   logic [NIN_W-1:0]             or_mag;
   logic [LEN_W-1:0]             len2_ff, len2_in;
   logic                         zero2_ff;
   logic [NIN_W-1:0]             shifted;
   logic [NORM_W-1:0]            m_out;
   norm_out_type                 out_ff, out_in;

   // take magnitudes; on fold, turn a vector with x < 0 by a half turn
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         raw_sgn[l] = norm_in.lane[l][NIN_W-1];
         mag1_in[l] = raw_sgn[l] ? (~norm_in.lane[l] + NIN_W'(1)) : norm_in.lane[l];
      end
      sgn1_in  = raw_sgn;
      half1_in = 1'b0;
      if (fold) begin
         half1_in   = raw_sgn[0];
         sgn1_in[0] = 1'b0;
         sgn1_in[1] = raw_sgn[1] ^ raw_sgn[0];
      end
   end

   // bit length of the largest magnitude equals that of the OR of all
   always_comb begin
      or_mag  = '0;
      len2_in = '0;
      for (int l = 0; l < LANES; l++) begin
         or_mag = or_mag | mag1_ff[l];
      end
      for (int b = 0; b < NIN_W; b++) begin
         if (or_mag[b]) begin
            len2_in = LEN_W'(b + 1);
         end
      end
   end

   // shift each magnitude into place and restore its sign
   always_comb begin
      shifted = '0;
      m_out   = '0;
      out_in  = '0;
      out_in.valid = v2_ff;
      out_in.zero  = zero2_ff;
      out_in.half  = half2_ff;
      for (int l = 0; l < LANES; l++) begin
         if (len2_ff > LEN_W'(NORM_TGT)) begin
            shifted = mag2_ff[l] >> (len2_ff - LEN_W'(NORM_TGT));
         end else begin
            shifted = mag2_ff[l] << (LEN_W'(NORM_TGT) - len2_ff);
         end
         m_out = shifted[NORM_W-1:0];
         out_in.lane[l] = sgn2_ff[l] ? (~m_out + NORM_W'(1)) : m_out;
      end
   end

   // advance valid bits and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff        <= norm_in.valid;
         v2_ff        <= v1_ff;
         out_ff.valid <= out_in.valid;
         half1_ff     <= half1_in;
         sgn1_ff      <= sgn1_in;
         mag1_ff      <= mag1_in;
         half2_ff     <= half1_ff;
         sgn2_ff      <= sgn1_ff;
         mag2_ff      <= mag1_ff;
         len2_ff      <= len2_in;
         zero2_ff     <= (or_mag == '0);
         out_ff.zero  <= out_in.zero;
         out_ff.half  <= out_in.half;
         out_ff.lane  <= out_in.lane;
      end
   end

   assign norm_out = out_ff;

endmodule

/* hdl/suvm_cordic_cell.sv */
`timescale 1ns / 1ps
// One CORDIC vectoring cell: rotates toward the x axis by atan(2^-step) and
// accumulates the angle. Depends on suvm_pkg.
module suvm_cordic_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic [suvm_pkg::STEP_W-1:0] step,
   input  suvm_pkg::cordic_rec_type cell_in,
   output suvm_pkg::cordic_rec_type cell_out
);
   import suvm_pkg::*;

   cordic_rec_type       rec_ff, rec_in;
   logic signed [CW-1:0] xs, ys;
   logic signed [AW-1:0] rot;

   // rotate by the sign of y
   always_comb begin
      xs     = $signed(cell_in.x) >>> step;
      ys     = $signed(cell_in.y) >>> step;
      rot    = $signed(atan_turn(step));
      rec_in = cell_in;
      if (!cell_in.y[CW-1]) begin
         rec_in.x   = cell_in.x + ys;
         rec_in.y   = cell_in.y - xs;
         rec_in.ang = cell_in.ang + rot;
      end else begin
         rec_in.x   = cell_in.x - ys;
         rec_in.y   = cell_in.y + xs;
         rec_in.ang = cell_in.ang - rot;
      end
   end

   // hand the record to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (adv) begin
         rec_ff <= rec_in;
      end
   end

   assign cell_out = rec_ff;

endmodule

/* hdl/suvm_isqrt_cell.sv */
`timescale 1ns / 1ps
// One digit-by-digit integer square root cell: settles one result bit, worth
// 4^step in the radicand. Depends on suvm_pkg.
module suvm_isqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic [suvm_pkg::STEP_W-1:0] step,
   input  suvm_pkg::isq_rec_type       cell_in,
   output suvm_pkg::isq_rec_type       cell_out
);
   import suvm_pkg::*;

   isq_rec_type      rec_ff, rec_in;
   logic [ISQ_W-1:0] bitv;
   logic [ISQ_W-1:0] trial;

   // subtract the trial value where it fits
   always_comb begin
      bitv   = ISQ_W'(1) << {step, 1'b0};
      trial  = cell_in.res + bitv;
      rec_in = cell_in;
      if (cell_in.n >= trial) begin
         rec_in.n   = cell_in.n - trial;
         rec_in.res = (cell_in.res >> 1) + bitv;
      end else begin
         rec_in.res = cell_in.res >> 1;
      end
   end

   // hand the record to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else if (adv) begin
         rec_ff <= rec_in;
      end
   end

   assign cell_out = rec_ff;

endmodule

/* hdl/sphere_uv_mapping.sv */
`timescale 1ns / 1ps
// Spherical UV mapping top level. Throughput: one request per cycle while the chain
// advances; the longest path runs through the chain of 31 square-root cells and
// one of the two chains of 28 CORDIC cells, all advancing together.
// The whole chain holds only while a result waits unread and another is due.
// Reset clears every valid bit; no clearing pass. Depends on suvm_pkg, suvm_norm,
// suvm_cordic_cell and suvm_isqrt_cell.
module sphere_uv_mapping (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  suvm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output suvm_pkg::rsp_type rsp_data
);
   import suvm_pkg::*;

   logic                        adv;
   logic                        last_valid;

   logic                        vd_ff;
   logic [LANES-1:0][NIN_W-1:0] diff_ff, diff_in;

   norm_in_type                 n1_in, nu_in, nv_in;
   norm_out_type                n1_out, nu_out, nv_out;

   cordic_rec_type              cu [CORDIC_STEPS+1];
   cordic_rec_type              cv [CORDIC_STEPS+1];
   isq_rec_type                 isq [ISQ_STEPS+1];

   logic signed [2*NORM_W-1:0]  sqx_in, sqz_in;
   logic [ISQ_W-1:0]            sqx_ff, sqz_ff;
   logic                        q1_valid_ff;
   isq_rec_type                 isq_head_ff, isq_head_in;

   logic [NORM_W-1:0]           dy_dly_ff [DY_DELAY];
   logic [UV_FRAC-1:0]          u_dly_ff [U_ALIGN];
   logic [U_ALIGN-1:0]          uv_dly_ff;
   logic [DEG_DELAY-1:0]        deg_dly_ff;

   logic [AW-1:0]               ang_u;
   logic [TURN_W:0]             u_sum;
   logic [UV_FRAC-1:0]          u_val;
   logic signed [AW-1:0]        ang_v;
   logic [TURN_W:0]             v_sum;
   logic [UV_FRAC:0]            v_val;

   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   // advance the chain unless a finished result would overwrite an unread one
   assign last_valid = cv[CORDIC_STEPS].valid;
   assign adv        = !rsp_valid_ff || rsp_ready || !last_valid;
   assign req_ready  = adv;

   // form the offset vector at accept
   always_comb begin
      diff_in[0] = {{(NIN_W-COORD_W){req_data.point_x[COORD_W-1]}}, req_data.point_x}
                 - {{(NIN_W-COORD_W){req_data.center_x[COORD_W-1]}}, req_data.center_x};
      diff_in[1] = {{(NIN_W-COORD_W){req_data.point_y[COORD_W-1]}}, req_data.point_y}
                 - {{(NIN_W-COORD_W){req_data.center_y[COORD_W-1]}}, req_data.center_y};
      diff_in[2] = {{(NIN_W-COORD_W){req_data.point_z[COORD_W-1]}}, req_data.point_z}
                 - {{(NIN_W-COORD_W){req_data.center_z[COORD_W-1]}}, req_data.center_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= diff_in;
      end
   end

   // normalize the offset
   assign n1_in.valid = vd_ff;
   assign n1_in.lane  = diff_ff;

   suvm_norm u_norm_d (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .fold     (1'b0),
      .norm_in  (n1_in),
      .norm_out (n1_out)
   );

   // longitude: atan2(dz, dx)
   assign nu_in.valid   = n1_out.valid;
   assign nu_in.lane[0] = {{(NIN_W-NORM_W){n1_out.lane[0][NORM_W-1]}}, n1_out.lane[0]};
   assign nu_in.lane[1] = {{(NIN_W-NORM_W){n1_out.lane[2][NORM_W-1]}}, n1_out.lane[2]};
   assign nu_in.lane[2] = '0;

   suvm_norm u_norm_u (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .fold     (1'b1),
      .norm_in  (nu_in),
      .norm_out (nu_out)
   );

   assign cu[0].valid = nu_out.valid;
   assign cu[0].zero  = nu_out.zero;
   assign cu[0].x     = {{(CW-NORM_W){nu_out.lane[0][NORM_W-1]}}, nu_out.lane[0]};
   assign cu[0].y     = {{(CW-NORM_W){nu_out.lane[1][NORM_W-1]}}, nu_out.lane[1]};
   assign cu[0].ang   = nu_out.half ? HALF_TURN : '0;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cu
      suvm_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step     (STEP_W'(g)),
         .cell_in  (cu[g]),
         .cell_out (cu[g+1])
      );
   end

   // round the turn fraction; a full turn wraps to zero
   always_comb begin
      ang_u = cu[CORDIC_STEPS].zero ? '0 : cu[CORDIC_STEPS].ang;
      u_sum = {1'b0, ang_u[TURN_W-1:0]} + ((TURN_W + 1)'(1) << (TURN_W - 1 - UV_FRAC));
      u_val = u_sum[TURN_W-1 -: UV_FRAC];
   end

   // hold u until the polar angle catches up
   always_ff @(posedge clock) begin
      if (reset) begin
         uv_dly_ff <= '0;
      end else if (adv) begin
         uv_dly_ff <= {uv_dly_ff[U_ALIGN-2:0], cu[CORDIC_STEPS].valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_dly_ff[0] <= u_val;
         for (int i = 1; i < U_ALIGN; i++) begin
            u_dly_ff[i] <= u_dly_ff[i-1];
         end
      end
   end

   // square and sum dx, dz for the radial length
   assign sqx_in = $signed(n1_out.lane[0]) * $signed(n1_out.lane[0]);
   assign sqz_in = $signed(n1_out.lane[2]) * $signed(n1_out.lane[2]);

   always_comb begin
      isq_head_in.valid = q1_valid_ff;
      isq_head_in.n     = sqx_ff + sqz_ff;
      isq_head_in.res   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff       <= 1'b0;
         isq_head_ff.valid <= 1'b0;
      end else if (adv) begin
         q1_valid_ff <= n1_out.valid;
         isq_head_ff <= isq_head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= sqx_in[ISQ_W-1:0];
         sqz_ff <= sqz_in[ISQ_W-1:0];
      end
   end

   assign isq[0] = isq_head_ff;

   for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_isq
      suvm_isqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step     (STEP_W'(ISQ_STEPS - 1 - g)),
         .cell_in  (isq[g]),
         .cell_out (isq[g+1])
      );
   end

   // hold dy while the square root runs
   always_ff @(posedge clock) begin
      if (adv) begin
         dy_dly_ff[0] <= n1_out.lane[1];
         for (int i = 1; i < DY_DELAY; i++) begin
            dy_dly_ff[i] <= dy_dly_ff[i-1];
         end
      end
   end

   // polar angle: atan2(r, dy)
   assign nv_in.valid   = isq[ISQ_STEPS].valid;
   assign nv_in.lane[0] = {{(NIN_W-NORM_W){dy_dly_ff[DY_DELAY-1][NORM_W-1]}},
                           dy_dly_ff[DY_DELAY-1]};
   assign nv_in.lane[1] = {{(NIN_W-NORM_W){1'b0}}, isq[ISQ_STEPS].res[NORM_W-1:0]};
   assign nv_in.lane[2] = '0;

   suvm_norm u_norm_v (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .fold     (1'b1),
      .norm_in  (nv_in),
      .norm_out (nv_out)
   );

   assign cv[0].valid = nv_out.valid;
   assign cv[0].zero  = nv_out.zero;
   assign cv[0].x     = {{(CW-NORM_W){nv_out.lane[0][NORM_W-1]}}, nv_out.lane[0]};
   assign cv[0].y     = {{(CW-NORM_W){nv_out.lane[1][NORM_W-1]}}, nv_out.lane[1]};
   assign cv[0].ang   = nv_out.half ? HALF_TURN : '0;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cv
      suvm_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step     (STEP_W'(g)),
         .cell_in  (cv[g]),
         .cell_out (cv[g+1])
      );
   end

   // clamp to [0, half turn] and round to the output fraction
   always_comb begin
      ang_v = cv[CORDIC_STEPS].ang;
      if (cv[CORDIC_STEPS].zero || ang_v < 0) begin
         ang_v = '0;
      end else if (ang_v > HALF_TURN) begin
         ang_v = HALF_TURN;
      end
      v_sum = {1'b0, ang_v[TURN_W-1:0]} + ((TURN_W + 1)'(1) << (TURN_W - 2 - UV_FRAC));
      v_val = v_sum[TURN_W-1 -: UV_FRAC + 1];
   end

   // carry the zero-offset flag along the longest path
   always_ff @(posedge clock) begin
      if (adv) begin
         deg_dly_ff <= {deg_dly_ff[DEG_DELAY-2:0], n1_out.zero};
      end
   end

   // output register
   always_comb begin
      rsp_in.u_coord    = u_dly_ff[U_ALIGN-1];
      rsp_in.v_coord    = v_val;
      rsp_in.degenerate = deg_dly_ff[DEG_DELAY-1];
      rsp_valid_in      = rsp_valid_ff;
      if (adv && last_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // u and v paths stay in step
   a_paths_aligned : assert property (@(posedge clock) disable iff (reset)
      uv_dly_ff[U_ALIGN-1] == last_valid)
      else $error("longitude and polar paths out of step");

   // a zero offset yields zero coordinates
   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.u_coord == '0 && rsp_data.v_coord == '0)
      else $error("degenerate request with nonzero coordinates");

   // v never exceeds one
   a_v_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.v_coord <= V_MAX)
      else $error("v_coord above one");

   // stall only while an unread result blocks a finished one
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && last_valid)
      else $error("chain stalled without cause");

endmodule
